// ===== hdl/rbcg_pkg.sv =====
// rbcg_pkg: shared types and constants for the rotated box corner generator
// angle scaling, cordic arctangent table, word kinds and pipeline payloads
// no dependencies
`timescale 1ns / 1ps

package rbcg_pkg;

	// angle units: 1/64 degree, one full turn
	localparam int TURN_UNITS    = 23040;
	localparam int HALF_UNITS    = TURN_UNITS / 2;
	localparam int QUARTER_UNITS = TURN_UNITS / 4;
	localparam int ANG_W         = 17;

	localparam logic signed [ANG_W-1:0] TURN_S     = ANG_W'(TURN_UNITS);
	localparam logic signed [ANG_W-1:0] HALF_S     = ANG_W'(HALF_UNITS);
	localparam logic signed [ANG_W-1:0] QUARTER_S  = ANG_W'(QUARTER_UNITS);
	localparam logic signed [ANG_W-1:0] TQUARTER_S = ANG_W'(3 * QUARTER_UNITS);

	// degrees to q30 radians: z = round(mag * PI_Q30 / HALF_UNITS)
	// split as mag * quotient + (mag * remainder + half) / HALF_UNITS
	localparam longint PI_Q30     = 64'sd3373259426;
	localparam logic [18:0] ZQ_C  = 19'(PI_Q30 / HALF_UNITS);
	localparam logic [12:0] ZR_C  = 13'(PI_Q30 % HALF_UNITS);
	localparam logic [25:0] ZRND_C = 26'(HALF_UNITS / 2);
	// HALF_UNITS = 2^8 * odd part; odd part divided by reciprocal multiply
	localparam int ZDIV_SHIFT  = 8;
	localparam int ZDIV_ODD    = HALF_UNITS >> ZDIV_SHIFT;
	localparam int RECIP_SHIFT = 25;
	localparam logic [19:0] RECIP_C = 20'(((64'sd1 << RECIP_SHIFT) + ZDIV_ODD - 1) / ZDIV_ODD);

	// cordic
	localparam int TABLE_LEN = 24;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
	localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	// result word kinds
	localparam logic [2:0] KIND_TL = 3'd0;
	localparam logic [2:0] KIND_TR = 3'd1;
	localparam logic [2:0] KIND_BL = 3'd2;
	localparam logic [2:0] KIND_BR = 3'd3;
	localparam logic [2:0] KIND_N0 = 3'd4;
	localparam logic [2:0] KIND_N1 = 3'd5;

	localparam logic signed [26:0] COORD_MAX = 27'sd8388607;
	localparam logic signed [26:0] COORD_MIN = -27'sd8388608;

	// box geometry carried alongside the angle
	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic [22:0]        w;
		logic [22:0]        h;
		logic               flip;
	} box_t;

	// cordic cell payload
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		box_t               box;
	} cordic_t;

	// finished box, ready for serialization
	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic [3:0][25:0]   ox;
		logic [3:0][25:0]   oy;
		logic signed [23:0] nc;
		logic signed [23:0] ns;
	} res_t;

endpackage

// ===== hdl/rbcg_front.sv =====
// rbcg_front: angle wrap and fold, conversion to q30 radians (four stages)
// depends on rbcg_pkg
`timescale 1ns / 1ps

module rbcg_front import rbcg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [23:0] center_x,
	input  logic signed [23:0] center_y,
	input  logic [22:0]        box_width,
	input  logic [22:0]        box_height,
	input  logic signed [15:0] angle_deg,
	output logic               out_valid,
	output cordic_t            out_d
);

	logic signed [ANG_W-1:0] a, r, f, mag_full;
	logic                    flip, neg;

	logic        v_s1, v_s2, v_s3;
	logic [12:0] mag_s1;
	logic        neg_s1, neg_s2, neg_s3;
	box_t        box_s1, box_s2, box_s3;
	logic [31:0] zq_s2, zq_s3;
	logic [25:0] lo_s2;
	logic [12:0] q_s3;
	logic [37:0] q_prod;
	logic [31:0] zsum;

	// wrap into one turn, then fold into plus or minus a quarter turn
	always_comb begin
		a    = {angle_deg[15], angle_deg};
		r    = a;
		f    = a;
		flip = 1'b0;
		if (a < 0) begin
			r = a + TURN_S;
			if (r < 0) begin
				r = r + TURN_S;
			end
		end else if (a >= TURN_S) begin
			r = a - TURN_S;
		end
		if (r > QUARTER_S && r <= TQUARTER_S) begin
			f    = r - HALF_S;
			flip = 1'b1;
		end else if (r > TQUARTER_S) begin
			f = r - TURN_S;
		end else begin
			f = r;
		end
		neg      = f[ANG_W-1];
		mag_full = neg ? -f : f;
	end

	// reciprocal multiply for the odd part of the divisor
	assign q_prod = {20'd0, lo_s2[25:ZDIV_SHIFT]} * {18'd0, RECIP_C};
	assign zsum   = zq_s3 + {19'd0, q_s3};

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1      <= mag_full[12:0];
			neg_s1      <= neg;
			box_s1      <= '{cx: center_x, cy: center_y, w: box_width, h: box_height,
				flip: flip};
			zq_s2       <= {19'd0, mag_s1} * {13'd0, ZQ_C};
			lo_s2       <= {13'd0, mag_s1} * {13'd0, ZR_C} + ZRND_C;
			neg_s2      <= neg_s1;
			box_s2      <= box_s1;
			zq_s3       <= zq_s2;
			q_s3        <= q_prod[37:RECIP_SHIFT];
			neg_s3      <= neg_s2;
			box_s3      <= box_s2;
			out_d.x     <= GAIN_Q30;
			out_d.y     <= '0;
			out_d.z     <= neg_s3 ? -$signed(zsum) : $signed(zsum);
			out_d.box   <= box_s3;
		end
	end

endmodule

// ===== hdl/rbcg_cordic_cell.sv =====
// rbcg_cordic_cell: one rotation-mode cordic iteration, registered
// depends on rbcg_pkg
`timescale 1ns / 1ps

module rbcg_cordic_cell import rbcg_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  cordic_t in_d,
	output logic    out_valid,
	output cordic_t out_d
);

	localparam logic signed [31:0] ATAN = $signed(ATAN_Q30[IDX]);

	logic signed [31:0] x, y, z, xs, ys;
	cordic_t            nxt;

	// rotate toward zero residual angle
	always_comb begin
		x  = in_d.x;
		y  = in_d.y;
		z  = in_d.z;
		xs = x >>> IDX;
		ys = y >>> IDX;
		nxt.box = in_d.box;
		if (!z[31]) begin
			nxt.x = x - ys;
			nxt.y = y + xs;
			nxt.z = z - ATAN;
		end else begin
			nxt.x = x + ys;
			nxt.y = y - xs;
			nxt.z = z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule

// ===== hdl/rbcg_post.sv =====
// rbcg_post: sign restore, face normals, size products and rounded corner offsets
// depends on rbcg_pkg
`timescale 1ns / 1ps

module rbcg_post import rbcg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  cordic_t in_d,
	output logic    out_valid,
	output res_t    out_d
);

	localparam logic signed [57:0] RND = 58'sd1 << 30;
	localparam logic signed [32:0] NRND = 33'sd1 << 15;

	logic               v_s1, v_s2;
	logic signed [31:0] c_s1, s_s1;
	box_t               box_s1, box_s2;
	logic signed [55:0] wc_s2, hs_s2, ws_s2, hc_s2;
	logic signed [23:0] nc_s2, ns_s2;
	logic signed [32:0] cr, sr;
	logic signed [57:0] ax, bx, ay, by;
	logic signed [57:0] rx [4];
	logic signed [57:0] ry [4];

	// normals rounded to 2^14 scale
	assign cr = {c_s1[31], c_s1} + NRND;
	assign sr = {s_s1[31], s_s1} + NRND;

	// four corners from the signed sums of the size products
	always_comb begin
		ax = 58'(wc_s2);
		bx = 58'(hs_s2);
		ay = 58'(ws_s2);
		by = 58'(hc_s2);
		for (int k = 0; k < 4; k++) begin
			rx[k] = (k[0] ? ax : -ax) + (k[1] ? -bx : bx) + RND;
			ry[k] = (k[0] ? ay : -ay) + (k[1] ? by : -by) + RND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1   <= in_d.box.flip ? -in_d.x : in_d.x;
			s_s1   <= in_d.box.flip ? -in_d.y : in_d.y;
			box_s1 <= in_d.box;
			wc_s2  <= $signed({1'b0, box_s1.w}) * c_s1;
			hs_s2  <= $signed({1'b0, box_s1.h}) * s_s1;
			ws_s2  <= $signed({1'b0, box_s1.w}) * s_s1;
			hc_s2  <= $signed({1'b0, box_s1.h}) * c_s1;
			nc_s2  <= {{7{cr[32]}}, cr[32:16]};
			ns_s2  <= {{7{sr[32]}}, sr[32:16]};
			box_s2 <= box_s1;
			out_d.cx <= box_s2.cx;
			out_d.cy <= box_s2.cy;
			for (int k = 0; k < 4; k++) begin
				out_d.ox[k] <= rx[k][56:31];
				out_d.oy[k] <= ry[k][56:31];
			end
			out_d.nc <= nc_s2;
			out_d.ns <= ns_s2;
		end
	end

endmodule

// ===== hdl/rbcg_serializer.sv =====
// rbcg_serializer: holds one finished box and sends its six words
// depends on rbcg_pkg
`timescale 1ns / 1ps

module rbcg_serializer import rbcg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  res_t               in_d,
	output logic               ready,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [2:0]         item_kind,
	output logic signed [23:0] out_x,
	output logic signed [23:0] out_y,
	output logic               last
);

	logic               hold_q;
	logic [2:0]         cnt_q;
	res_t               bank_q;
	logic               out_free, emit, done, take;
	logic [1:0]         ci;
	logic signed [26:0] sx, sy;
	logic signed [23:0] wx, wy;

	// handshake between held box and output register
	always_comb begin
		out_free = !res_valid || !res_stall;
		emit     = hold_q && out_free;
		done     = emit && (cnt_q == KIND_N1);
		ready    = !hold_q || done;
		take     = in_valid && ready;
	end

	// word select: corner with saturation, or a normal
	always_comb begin
		ci = cnt_q[1:0];
		sx = {{3{bank_q.cx[23]}}, bank_q.cx} + {bank_q.ox[ci][25], bank_q.ox[ci]};
		sy = {{3{bank_q.cy[23]}}, bank_q.cy} + {bank_q.oy[ci][25], bank_q.oy[ci]};
		case (cnt_q)
			KIND_N0: begin
				wx = bank_q.nc;
				wy = bank_q.ns;
			end
			KIND_N1: begin
				wx = -bank_q.ns;
				wy = bank_q.nc;
			end
			default: begin
				wx = (sx > COORD_MAX) ? COORD_MAX[23:0] :
					(sx < COORD_MIN) ? COORD_MIN[23:0] : sx[23:0];
				wy = (sy > COORD_MAX) ? COORD_MAX[23:0] :
					(sy < COORD_MIN) ? COORD_MIN[23:0] : sy[23:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= 1'b0;
			cnt_q     <= KIND_TL;
			res_valid <= 1'b0;
		end else begin
			if (take) begin
				hold_q <= 1'b1;
			end else if (done) begin
				hold_q <= 1'b0;
			end
			if (done) begin
				cnt_q <= KIND_TL;
			end else if (emit) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (emit) begin
				res_valid <= 1'b1;
			end else if (out_free) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bank_q <= in_d;
		end
		if (emit) begin
			item_kind <= cnt_q;
			out_x     <= wx;
			out_y     <= wy;
			last      <= (cnt_q == KIND_N1);
		end
	end

endmodule

// ===== hdl/rotated_box_corner_generator.sv =====
// the six-word serializer sets the box rate; it takes a new box as it sends the last word
// reset clears all valid flags and the word counter; no clearing pass
// rotated_box_corner_generator: top level, chains front, cordic cells, post and serializer
// depends on rbcg_pkg, rbcg_front, rbcg_cordic_cell, rbcg_post, rbcg_serializer
`timescale 1ns / 1ps

module rotated_box_corner_generator import rbcg_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               box_valid,
	output logic               box_stall,
	input  logic signed [23:0] center_x,
	input  logic signed [23:0] center_y,
	input  logic [22:0]        box_width,
	input  logic [22:0]        box_height,
	input  logic signed [15:0] angle_deg,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [2:0]         item_kind,
	output logic signed [23:0] out_x,
	output logic signed [23:0] out_y,
	output logic               last
);

	localparam int NCELL = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

	logic    en, ser_ready, post_valid;
	res_t    post_d;
	logic    chain_v [NCELL+1];
	cordic_t chain_d [NCELL+1];

	// whole pipeline advances unless the box at its end waits on the serializer
	assign en        = !post_valid || ser_ready;
	assign box_stall = !en;

	rbcg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (box_valid),
		.center_x   (center_x),
		.center_y   (center_y),
		.box_width  (box_width),
		.box_height (box_height),
		.angle_deg  (angle_deg),
		.out_valid  (chain_v[0]),
		.out_d      (chain_d[0])
	);

	// row of cordic cells, one iteration each
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		rbcg_cordic_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_v[i]),
			.in_d      (chain_d[i]),
			.out_valid (chain_v[i+1]),
			.out_d     (chain_d[i+1])
		);
	end

	rbcg_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (chain_v[NCELL]),
		.in_d      (chain_d[NCELL]),
		.out_valid (post_valid),
		.out_d     (post_d)
	);

	rbcg_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (post_valid),
		.in_d      (post_d),
		.ready     (ser_ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.item_kind (item_kind),
		.out_x     (out_x),
		.out_y     (out_y),
		.last      (last)
	);

endmodule

// ===== hdl/rbcg_checker.sv =====
// rbcg_checker: port-level checks on the result word stream, bound to the top level
// depends on rbcg_pkg and rotated_box_corner_generator
`timescale 1ns / 1ps

module rbcg_checker import rbcg_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input logic [2:0]         item_kind,
	input logic signed [23:0] out_x,
	input logic signed [23:0] out_y,
	input logic               last
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(item_kind) && $stable(out_x)
			&& $stable(out_y) && $stable(last))
		else $error("stalled result word changed");

	// last marks the second normal only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (last == (item_kind == KIND_N1)))
		else $error("last flag does not match word kind");

	// kinds count up inside a box
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !last) ##1 res_valid |->
			item_kind == $past(item_kind) + 3'd1)
		else $error("word kind skipped or repeated");

	// a new box starts with the top-left corner
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && last) ##1 res_valid |-> item_kind == KIND_TL)
		else $error("box did not start with top-left corner");

	// second normal is the first one turned a quarter
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && item_kind == KIND_N0) ##1 res_valid |->
			out_y == $past(out_x) && out_x == -$past(out_y))
		else $error("face normals are not perpendicular");

endmodule

bind rotated_box_corner_generator rbcg_checker u_rbcg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.item_kind  (item_kind),
	.out_x      (out_x),
	.out_y      (out_y),
	.last       (last)
);

// ===== tb/rotated_box_corner_generator_tb.sv =====
// rotated_box_corner_generator_tb: self-checking testbench for the rotated box corner generator
// predicts the four corners and two face normals of every accepted box and checks each result word
// depends on rbcg_pkg and rotated_box_corner_generator
`timescale 1ns / 1ps

module rotated_box_corner_generator_tb import rbcg_pkg::*; ();

	localparam int STAGES      = 16;
	localparam int ROT_STAGES  = (STAGES > 24) ? 24 : STAGES;
	localparam longint TURN    = 23040;
	localparam longint HALF    = 11520;
	localparam longint QUARTER = 5760;
	localparam longint PI_Q30  = 64'sd3373259426;
	localparam longint GAIN    = 64'sd652032874;
	localparam longint SAT_HI  = 64'sd8388607;
	localparam longint SAT_LO  = -64'sd8388608;
	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_WAIT  = 40;

	// arctangent steps in q30 radians
	localparam longint ATAN_STEP [24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic [22:0]        w;
		logic [22:0]        h;
		logic signed [15:0] ang;
	} box_in_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic               last;
	} box_word_t;

	logic               clk;
	logic               arst_n;
	logic               box_valid;
	logic               box_stall;
	logic signed [23:0] center_x;
	logic signed [23:0] center_y;
	logic [22:0]        box_width;
	logic [22:0]        box_height;
	logic signed [15:0] angle_deg;
	logic               res_valid;
	logic               res_stall;
	logic [2:0]         item_kind;
	logic signed [23:0] out_x;
	logic signed [23:0] out_y;
	logic               last;

	box_word_t box_words_due[$];
	int        error_count;
	int        sender_idle_pct;
	int        receiver_stall_pct;
	int        quiet_cycles;

	rotated_box_corner_generator #(
		.CORDIC_STAGES(STAGES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.box_valid (box_valid),
		.box_stall (box_stall),
		.center_x  (center_x),
		.center_y  (center_y),
		.box_width (box_width),
		.box_height(box_height),
		.angle_deg (angle_deg),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.item_kind (item_kind),
		.out_x     (out_x),
		.out_y     (out_y),
		.last      (last)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// cos and sin of an angle in 1/64 degree units, both in q30
	function automatic void rotate_unit(input longint ang, output longint cos_q30,
			output longint sin_q30);
		longint r, z, x, y, xs, ys, mag;
		bit     flip;
		int     i;
		r = ang % TURN;
		if (r < 0)
			r += TURN;
		flip = 1'b0;
		// fold into (-90, +90] degrees, negating the result for the far half
		if (r > QUARTER && r <= 3 * QUARTER) begin
			r -= HALF;
			flip = 1'b1;
		end else if (r > 3 * QUARTER) begin
			r -= TURN;
		end
		mag = (r < 0) ? -r : r;
		z = (mag * PI_Q30 + HALF / 2) / HALF;
		if (r < 0)
			z = -z;
		x = GAIN;
		y = 0;
		for (i = 0; i < ROT_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= ATAN_STEP[i];
			end else begin
				x += ys;
				y -= xs;
				z += ATAN_STEP[i];
			end
		end
		cos_q30 = flip ? -x : x;
		sin_q30 = flip ? -y : y;
	endfunction

	function automatic logic signed [23:0] clamp24(input longint v);
		if (v > SAT_HI)
			return SAT_HI[23:0];
		if (v < SAT_LO)
			return SAT_LO[23:0];
		return v[23:0];
	endfunction

	// six words of one box: four corners then the two face normals
	function automatic void predict_box_words(input box_in_t b);
		logic [2:0] corner_kind [4];
		longint     c, s, cx, cy, w, h, dx, dy, rx, ry, ox, oy, c14, s14;
		box_word_t  wd;
		int         k;
		corner_kind = '{KIND_TL, KIND_TR, KIND_BL, KIND_BR};
		rotate_unit(longint'(b.ang), c, s);
		cx = longint'(b.cx);
		cy = longint'(b.cy);
		w  = longint'({1'b0, b.w});
		h  = longint'({1'b0, b.h});
		for (k = 0; k < 4; k++) begin
			dx = k[0] ? w : -w;
			dy = k[1] ? h : -h;
			rx = dx * c - dy * s;
			ry = dx * s + dy * c;
			// rounding here also halves the full width and height
			ox = (rx + (longint'(1) <<< 30)) >>> 31;
			oy = (ry + (longint'(1) <<< 30)) >>> 31;
			wd.kind = corner_kind[k];
			wd.x    = clamp24(cx + ox);
			wd.y    = clamp24(cy + oy);
			wd.last = 1'b0;
			box_words_due.push_back(wd);
		end
		c14 = (c + (longint'(1) <<< 15)) >>> 16;
		s14 = (s + (longint'(1) <<< 15)) >>> 16;
		wd.kind = KIND_N0;
		wd.x    = c14[23:0];
		wd.y    = s14[23:0];
		wd.last = 1'b0;
		box_words_due.push_back(wd);
		wd.kind = KIND_N1;
		wd.x    = -s14[23:0];
		wd.y    = c14[23:0];
		wd.last = 1'b1;
		box_words_due.push_back(wd);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		box_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (box_words_due.size() == 0) begin
				report_mismatch("unexpected word, kind", item_kind, -1);
			end else begin
				want = box_words_due.pop_front();
				if (item_kind !== want.kind)
					report_mismatch("item_kind", item_kind, want.kind);
				if (out_x !== want.x)
					report_mismatch("out_x", out_x, want.x);
				if (out_y !== want.y)
					report_mismatch("out_y", out_y, want.y);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((box_valid && !box_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic set_idling(input int idle_pct, input int stall_pct);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
	endtask

	// send one box and predict its words once accepted
	task automatic send_box(input box_in_t b);
		while ($urandom_range(99, 0) < sender_idle_pct) begin
			box_valid <= 1'b0;
			@(posedge clk);
		end
		box_valid  <= 1'b1;
		center_x   <= b.cx;
		center_y   <= b.cy;
		box_width  <= b.w;
		box_height <= b.h;
		angle_deg  <= b.ang;
		do
			@(posedge clk);
		while (box_stall);
		predict_box_words(b);
	endtask

	task automatic send_fields(input int cx, input int cy, input int w, input int h, input int ang);
		box_in_t b;
		b.cx  = cx[23:0];
		b.cy  = cy[23:0];
		b.w   = w[22:0];
		b.h   = h[22:0];
		b.ang = ang[15:0];
		send_box(b);
	endtask

	// sizes, centers, saturation and collapsed boxes
	task automatic test_extremes();
		send_fields(0, 0, 0, 0, 0);
		send_fields(0, 0, 8388607, 8388607, 0);
		send_fields(8388607, 8388607, 8388607, 8388607, 0);
		send_fields(-8388608, -8388608, 8388607, 8388607, 0);
		send_fields(8388607, -8388608, 8388607, 8388607, 2880);
		send_fields(-8388608, 8388607, 8388607, 1, -8000);
		send_fields(1000, -2000, 0, 12345, 2880);
		send_fields(-500, 700, 54321, 0, -1920);
		send_fields(256, 256, 512, 256, 1);
		send_fields(0, 0, 1, 1, 23039);
	endtask

	// quadrant folds and angle wrap
	task automatic test_angle_folds();
		int fold_angle [12];
		int i;
		fold_angle = '{5760, 5761, 11520, 17280, 17281, -5760, -5761, -11520,
			-17280, 23039, -23040, -1};
		for (i = 0; i < 12; i++)
			send_fields(12800, -6400, 4096, 2048, fold_angle[i]);
	endtask

	// random boxes: mostly realistic sizes, some full-range fields
	task automatic test_random_boxes(input int count);
		box_in_t b;
		int      n, shape, ang;
		for (n = 0; n < count; n++) begin
			shape = $urandom_range(3, 0);
			ang   = int'($urandom_range(46079, 0)) - 23040;
			b.ang = ang[15:0];
			b.cx  = 24'($urandom());
			b.cy  = 24'($urandom());
			b.w   = 23'($urandom());
			b.h   = 23'($urandom());
			if (shape == 1 || shape == 2) begin
				b.cx = {{4{b.cx[19]}}, b.cx[19:0]};
				b.cy = {{4{b.cy[19]}}, b.cy[19:0]};
				b.w  = {7'd0, b.w[15:0]};
				b.h  = {7'd0, b.h[15:0]};
			end else if (shape == 3) begin
				b.w = {15'd0, b.w[7:0]};
				b.h = {15'd0, b.h[7:0]};
			end
			send_box(b);
		end
	endtask

	// random boxes under each idling pattern
	task automatic test_idling_phases();
		set_idling(0, 0);
		test_random_boxes(90);
		set_idling(52, 0);
		test_random_boxes(90);
		set_idling(0, 52);
		test_random_boxes(90);
		set_idling(20, 20);
		test_random_boxes(90);
	endtask

	initial begin
		error_count  = 0;
		quiet_cycles = 0;
		set_idling(0, 0);
		arst_n     = 1'b0;
		box_valid  = 1'b0;
		res_stall  = 1'b0;
		center_x   = '0;
		center_y   = '0;
		box_width  = '0;
		box_height = '0;
		angle_deg  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_angle_folds();
		test_idling_phases();

		// drain
		box_valid <= 1'b0;
		while (box_words_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
